FILE: src/incremental_convex_hull_3d_top_defines.svh
// Assertion macros used by the hull controller RTL
`ifndef INCREMENTAL_CONVEX_HULL_3D_TOP_DEFINES_SVH
`define INCREMENTAL_CONVEX_HULL_3D_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ICHULL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ICHULL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ICHULL_ASSERT(lbl, prop, msg)
`define ICHULL_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: src/ichull_pkg.sv
package ichull_pkg;

    localparam int MAX_POINTS  = 32;
    localparam int MAX_FACES   = 64;
    localparam int HOR_DEPTH   = 64;
    localparam int MAX_RESULTS = 60;
    localparam int EMIT_MAX    = (MAX_RESULTS < MAX_FACES) ? MAX_RESULTS : MAX_FACES;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 5;
    localparam int STAT_W    = 2;
    localparam int TOL_W     = 32;
    localparam int CFG_IDX_W = 8;

    localparam int PT_AW   = $clog2(MAX_POINTS);
    localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
    localparam int FA_W    = $clog2(MAX_FACES);
    localparam int FCNT_W  = $clog2(MAX_FACES + 1);
    localparam int HA_W    = $clog2(HOR_DEPTH);
    localparam int HCNT_W  = $clog2(HOR_DEPTH + 1);
    localparam int PT_W    = 3 * COORD_W;
    localparam int FACE_W  = 3 * PT_AW;
    localparam int EDGE_W  = 2 * PT_AW;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int NRM_W   = 2 * DIFF_W + 1;
    localparam int PROD_W  = NRM_W + DIFF_W;
    localparam int VOL_W   = PROD_W + 1;
    localparam int VCNT_W  = 5;

    typedef logic [PT_AW-1:0]  t_pidx;
    typedef logic [PCNT_W-1:0] t_pcnt;
    typedef logic [FA_W-1:0]   t_faddr;
    typedef logic [FCNT_W-1:0] t_fcnt;
    typedef logic [HA_W-1:0]   t_haddr;
    typedef logic [HCNT_W-1:0] t_hcnt;

    localparam t_pcnt PCNT_MAX   = t_pcnt'(MAX_POINTS);
    localparam t_pcnt PCNT_MIN   = t_pcnt'(4);
    localparam t_pcnt PIDX_FIRST = t_pcnt'(3);
    localparam t_fcnt FCNT_MAX   = t_fcnt'(MAX_FACES);
    localparam t_fcnt EMIT_CAP   = t_fcnt'(EMIT_MAX);
    localparam t_hcnt HCNT_MAX   = t_hcnt'(HOR_DEPTH);

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd16777;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIS_TOL   = 8'd1;

    localparam logic [STAT_W-1:0] ST_FACE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FLAT = 2'd2;

    typedef enum logic [1:0] {FW_LATCH, FW_HOR, FW_SEED} t_fsrc;
    typedef enum logic {HW_EDGE, HW_SHIFT} t_hsrc;
    typedef enum logic [1:0] {E_AB, E_BC, E_CA} t_esel;

    typedef struct packed {
        logic                  pt_we;
        t_pidx                 pt_addr;
        logic                  vol_start;
        logic                  vol_face;
        t_pidx                 tri_a;
        t_pidx                 tri_b;
        t_pidx                 tri_c;
        t_pidx                 pidx;
        logic                  face_we;
        t_faddr                face_waddr;
        t_faddr                face_raddr;
        t_fsrc                 fsrc;
        logic                  face_latch;
        t_esel                 esel;
        logic                  hor_we;
        t_haddr                hor_waddr;
        t_haddr                hor_raddr;
        t_hsrc                 hsrc;
        logic                  out_load;
        logic                  out_face;
        logic [STAT_W-1:0]     out_code;
        logic                  out_last;
    } t_cmd;

    typedef struct packed {
        logic vol_done;
        logic vol_lt_p;
        logic vol_gt_p;
        logic vol_gt_v;
        logic edge_match;
        logic out_free;
    } t_stat;

endpackage

FILE: src/ichull_if.sv
interface ichull_pt_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ichull_pkg::COORD_W-1:0]  coord_x;
    logic signed [ichull_pkg::COORD_W-1:0]  coord_y;
    logic signed [ichull_pkg::COORD_W-1:0]  coord_z;
    logic                                   last_vertex;

    modport source (output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

interface ichull_face_if;
    logic                               valid;
    logic                               ready;
    logic [ichull_pkg::IDX_W-1:0]       corner_a;
    logic [ichull_pkg::IDX_W-1:0]       corner_b;
    logic [ichull_pkg::IDX_W-1:0]       corner_c;
    logic [ichull_pkg::STAT_W-1:0]      status;
    logic                               last_face;

    modport source (output valid, corner_a, corner_b, corner_c, status, last_face,
                    input ready);
    modport sink   (input valid, corner_a, corner_b, corner_c, status, last_face,
                    output ready);
endinterface

interface ichull_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ichull_pkg::CFG_IDX_W-1:0]   index;
    logic [ichull_pkg::TOL_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/incremental_convex_hull_3d_top.sv
// Incremental 3D convex hull engine.
// i_pt: point requests (signed Q8.8 x, y, z and last_vertex). Points are taken
//   one per cycle when ready into a 32-entry store; a request with last_vertex
//   set ends the set and starts the hull build. Points beyond 32 are dropped.
// o_face: one request per face up to 60 (corner indices, status, last_face),
//   or a single status request when the set is too small or coplanar.
// i_cfg: register writes, index 0 plane tolerance, index 1 visibility
//   tolerance; always ready, write only while the block is idle.
// Each orientation test runs in a shared volume unit: 4 point-store reads,
//   one difference stage and 9 products through one 35x17 multiplier. The
//   build runs one test per stored face for each added point, plus linear
//   horizon scans and compaction.
// Faces stream out (read, then output load) while the receiver takes them.
// Input ready stays low from the last point until the final result has been
//   handed to the output register. A stalled receiver holds the output
//   register and halts the face readout.
// Reset clears counters and restores both tolerances to 16777.
module incremental_convex_hull_3d_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ichull_pt_if.sink     i_pt,
    ichull_face_if.source o_face,
    ichull_cfg_if.sink    i_cfg
);

    ichull_pkg::t_cmd  w_cmd;
    ichull_pkg::t_stat w_stat;

    ichull_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_in_last  (i_pt.last_vertex),
        .o_in_ready (i_pt.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ichull_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_coord_x    (i_pt.coord_x),
        .i_coord_y    (i_pt.coord_y),
        .i_coord_z    (i_pt.coord_z),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_face_valid (o_face.valid),
        .i_face_ready (o_face.ready),
        .o_corner_a   (o_face.corner_a),
        .o_corner_b   (o_face.corner_b),
        .o_corner_c   (o_face.corner_c),
        .o_status     (o_face.status),
        .o_last_face  (o_face.last_face)
    );

endmodule

FILE: src/ichull_ram.sv
module ichull_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ichull_vol.sv
module ichull_vol (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  ichull_pkg::t_pidx                   i_a,
    input  ichull_pkg::t_pidx                   i_b,
    input  ichull_pkg::t_pidx                   i_c,
    input  ichull_pkg::t_pidx                   i_p,
    output ichull_pkg::t_pidx                   o_pt_raddr,
    input  logic [ichull_pkg::PT_W-1:0]         i_pt_rdata,
    output logic                                o_done,
    output logic signed [ichull_pkg::VOL_W-1:0] o_vol
);

    localparam int CW = ichull_pkg::COORD_W;
    localparam int DW = ichull_pkg::DIFF_W;
    localparam int NW = ichull_pkg::NRM_W;
    localparam int PW = ichull_pkg::PROD_W;
    localparam int VW = ichull_pkg::VOL_W;
    localparam int TW = ichull_pkg::VCNT_W;

    function automatic logic signed [DW-1:0] dsub(
        input logic [CW-1:0] u,
        input logic [CW-1:0] v
    );
        return $signed({u[CW-1], u}) - $signed({v[CW-1], v});
    endfunction

    logic                       r_busy;
    logic                       r_done;
    logic [TW-1:0]              r_cnt;
    ichull_pkg::t_pidx          r_ia, r_ib, r_ic, r_ip;
    logic [ichull_pkg::PT_W-1:0] r_pa, r_pb, r_pc, r_pp;
    logic signed [DW-1:0]       r_bx, r_by, r_bz, r_cx, r_cy, r_cz, r_qx, r_qy, r_qz;
    logic signed [NW-1:0]       r_nx, r_ny, r_nz;
    logic signed [PW-1:0]       r_prod;
    logic [3:0]                 r_pk;
    logic                       r_pv;
    logic signed [VW-1:0]       r_acc;
    logic [3:0]                 w_k;
    logic signed [NW-1:0]       w_op1;
    logic signed [DW-1:0]       w_op2;
    logic                       w_issue;

    assign w_k     = 4'(r_cnt - TW'(6));
    assign w_issue = r_busy && (r_cnt >= TW'(6)) && (r_cnt <= TW'(14));

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    o_pt_raddr = r_ia;
            2'd1:    o_pt_raddr = r_ib;
            2'd2:    o_pt_raddr = r_ic;
            default: o_pt_raddr = r_ip;
        endcase
    end

    always_comb begin
        unique case (w_k)
            4'd0:    begin w_op1 = NW'(r_by); w_op2 = r_cz; end
            4'd1:    begin w_op1 = NW'(r_bz); w_op2 = r_cy; end
            4'd2:    begin w_op1 = NW'(r_bz); w_op2 = r_cx; end
            4'd3:    begin w_op1 = NW'(r_bx); w_op2 = r_cz; end
            4'd4:    begin w_op1 = NW'(r_bx); w_op2 = r_cy; end
            4'd5:    begin w_op1 = NW'(r_by); w_op2 = r_cx; end
            4'd6:    begin w_op1 = r_nx;      w_op2 = r_qx; end
            4'd7:    begin w_op1 = r_ny;      w_op2 = r_qy; end
            default: begin w_op1 = r_nz;      w_op2 = r_qz; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_pv   <= w_issue;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + TW'(1);
                if (r_cnt == TW'(15)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ia <= i_a;
            r_ib <= i_b;
            r_ic <= i_c;
            r_ip <= i_p;
        end
        if (r_busy) begin
            unique case (r_cnt)
                TW'(1):  r_pa <= i_pt_rdata;
                TW'(2):  r_pb <= i_pt_rdata;
                TW'(3):  r_pc <= i_pt_rdata;
                TW'(4):  r_pp <= i_pt_rdata;
                TW'(5):  begin
                    r_bx <= dsub(r_pb[3*CW-1:2*CW], r_pa[3*CW-1:2*CW]);
                    r_by <= dsub(r_pb[2*CW-1:CW],   r_pa[2*CW-1:CW]);
                    r_bz <= dsub(r_pb[CW-1:0],      r_pa[CW-1:0]);
                    r_cx <= dsub(r_pc[3*CW-1:2*CW], r_pa[3*CW-1:2*CW]);
                    r_cy <= dsub(r_pc[2*CW-1:CW],   r_pa[2*CW-1:CW]);
                    r_cz <= dsub(r_pc[CW-1:0],      r_pa[CW-1:0]);
                    r_qx <= dsub(r_pp[3*CW-1:2*CW], r_pa[3*CW-1:2*CW]);
                    r_qy <= dsub(r_pp[2*CW-1:CW],   r_pa[2*CW-1:CW]);
                    r_qz <= dsub(r_pp[CW-1:0],      r_pa[CW-1:0]);
                end
                default: ;
            endcase
        end
        if (w_issue) begin
            r_prod <= w_op1 * w_op2;
            r_pk   <= w_k;
        end
        if (r_pv) begin
            unique case (r_pk)
                4'd0:    r_nx  <= NW'(r_prod);
                4'd1:    r_nx  <= r_nx - NW'(r_prod);
                4'd2:    r_ny  <= NW'(r_prod);
                4'd3:    r_ny  <= r_ny - NW'(r_prod);
                4'd4:    r_nz  <= NW'(r_prod);
                4'd5:    r_nz  <= r_nz - NW'(r_prod);
                4'd6:    r_acc <= VW'(r_prod);
                default: r_acc <= r_acc + VW'(r_prod);
            endcase
        end
    end

    assign o_done = r_done;
    assign o_vol  = r_acc;

endmodule

FILE: src/ichull_dp.sv
module ichull_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ichull_pkg::t_cmd                        i_cmd,
    output ichull_pkg::t_stat                       o_stat,
    input  logic [ichull_pkg::COORD_W-1:0]          i_coord_x,
    input  logic [ichull_pkg::COORD_W-1:0]          i_coord_y,
    input  logic [ichull_pkg::COORD_W-1:0]          i_coord_z,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ichull_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ichull_pkg::TOL_W-1:0]            i_cfg_data,
    output logic                                    o_face_valid,
    input  logic                                    i_face_ready,
    output logic [ichull_pkg::IDX_W-1:0]            o_corner_a,
    output logic [ichull_pkg::IDX_W-1:0]            o_corner_b,
    output logic [ichull_pkg::IDX_W-1:0]            o_corner_c,
    output logic [ichull_pkg::STAT_W-1:0]           o_status,
    output logic                                    o_last_face
);

    localparam int AW = ichull_pkg::PT_AW;
    localparam int VW = ichull_pkg::VOL_W;
    localparam int TW = ichull_pkg::TOL_W;
    localparam int XW = ichull_pkg::IDX_W;

    logic [TW-1:0]                      r_ptol, r_vtol;
    ichull_pkg::t_pidx                  r_a, r_b, r_c;
    logic                               r_ovalid;
    logic [XW-1:0]                      r_oa, r_ob, r_oc;
    logic [ichull_pkg::STAT_W-1:0]      r_ocode;
    logic                               r_olast;

    ichull_pkg::t_pidx                  w_pt_raddr;
    logic [ichull_pkg::PT_W-1:0]        w_pt_rdata;
    logic [ichull_pkg::FACE_W-1:0]      w_face_rdata, w_face_wdata;
    logic [ichull_pkg::EDGE_W-1:0]      w_hor_rdata, w_hor_wdata;
    ichull_pkg::t_pidx                  w_fa, w_fb, w_fc, w_hu, w_hv, w_eu, w_ev;
    ichull_pkg::t_pidx                  w_va, w_vb, w_vc;
    logic                               w_vdone;
    logic signed [VW-1:0]               w_vol, w_ptol, w_vtol;

    assign w_fa = w_face_rdata[3*AW-1:2*AW];
    assign w_fb = w_face_rdata[2*AW-1:AW];
    assign w_fc = w_face_rdata[AW-1:0];
    assign w_hu = w_hor_rdata[2*AW-1:AW];
    assign w_hv = w_hor_rdata[AW-1:0];

    ichull_ram #(.WIDTH(ichull_pkg::PT_W), .DEPTH(ichull_pkg::MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pt_we),
        .i_waddr (i_cmd.pt_addr),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z}),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    always_comb begin
        unique case (i_cmd.fsrc)
            ichull_pkg::FW_HOR:  w_face_wdata = {w_hu, w_hv, i_cmd.pidx};
            ichull_pkg::FW_SEED: w_face_wdata = {i_cmd.tri_a, i_cmd.tri_b, i_cmd.tri_c};
            default:             w_face_wdata = {r_a, r_b, r_c};
        endcase
    end

    ichull_ram #(.WIDTH(ichull_pkg::FACE_W), .DEPTH(ichull_pkg::MAX_FACES)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.face_we),
        .i_waddr (i_cmd.face_waddr),
        .i_wdata (w_face_wdata),
        .i_raddr (i_cmd.face_raddr),
        .o_rdata (w_face_rdata)
    );

    always_comb begin
        unique case (i_cmd.esel)
            ichull_pkg::E_BC: begin w_eu = r_b; w_ev = r_c; end
            ichull_pkg::E_CA: begin w_eu = r_c; w_ev = r_a; end
            default:          begin w_eu = r_a; w_ev = r_b; end
        endcase
    end

    assign w_hor_wdata = (i_cmd.hsrc == ichull_pkg::HW_SHIFT) ? w_hor_rdata : {w_eu, w_ev};

    ichull_ram #(.WIDTH(ichull_pkg::EDGE_W), .DEPTH(ichull_pkg::HOR_DEPTH)) u_hor_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hor_we),
        .i_waddr (i_cmd.hor_waddr),
        .i_wdata (w_hor_wdata),
        .i_raddr (i_cmd.hor_raddr),
        .o_rdata (w_hor_rdata)
    );

    assign w_va = i_cmd.vol_face ? w_fa : i_cmd.tri_a;
    assign w_vb = i_cmd.vol_face ? w_fb : i_cmd.tri_b;
    assign w_vc = i_cmd.vol_face ? w_fc : i_cmd.tri_c;

    ichull_vol u_vol (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.vol_start),
        .i_a        (w_va),
        .i_b        (w_vb),
        .i_c        (w_vc),
        .i_p        (i_cmd.pidx),
        .o_pt_raddr (w_pt_raddr),
        .i_pt_rdata (w_pt_rdata),
        .o_done     (w_vdone),
        .o_vol      (w_vol)
    );

    assign w_ptol = $signed({{(VW-TW){1'b0}}, r_ptol});
    assign w_vtol = $signed({{(VW-TW){1'b0}}, r_vtol});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptol <= ichull_pkg::TOL_RESET;
            r_vtol <= ichull_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ichull_pkg::REG_PLANE_TOL) begin
                r_ptol <= i_cfg_data;
            end else if (i_cfg_index == ichull_pkg::REG_VIS_TOL) begin
                r_vtol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.face_latch) begin
            r_a <= w_fa;
            r_b <= w_fb;
            r_c <= w_fc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_face_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oa    <= i_cmd.out_face ? XW'(w_fa) : '0;
            r_ob    <= i_cmd.out_face ? XW'(w_fb) : '0;
            r_oc    <= i_cmd.out_face ? XW'(w_fc) : '0;
            r_ocode <= i_cmd.out_code;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_stat.vol_done   = w_vdone;
    assign o_stat.vol_lt_p   = w_vol < -w_ptol;
    assign o_stat.vol_gt_p   = w_vol > w_ptol;
    assign o_stat.vol_gt_v   = w_vol > w_vtol;
    assign o_stat.edge_match = ((w_hu == w_eu) && (w_hv == w_ev)) ||
                               ((w_hu == w_ev) && (w_hv == w_eu));
    assign o_stat.out_free   = !r_ovalid || i_face_ready;

    assign o_cfg_ready  = 1'b1;
    assign o_face_valid = r_ovalid;
    assign o_corner_a   = r_oa;
    assign o_corner_b   = r_ob;
    assign o_corner_c   = r_oc;
    assign o_status     = r_ocode;
    assign o_last_face  = r_olast;

endmodule

FILE: src/ichull_ctl.sv
`include "incremental_convex_hull_3d_top_defines.svh"

module ichull_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  ichull_pkg::t_stat  i_stat,
    output ichull_pkg::t_cmd   o_cmd
);

    typedef enum logic [19:0] {
        S_LOAD      = 20'h00001,
        S_CHK       = 20'h00002,
        S_SEED_GO   = 20'h00004,
        S_SEED_WAIT = 20'h00008,
        S_SEED_PUSH = 20'h00010,
        S_ADD_NEXT  = 20'h00020,
        S_FACE_RD   = 20'h00040,
        S_FACE_LAT  = 20'h00080,
        S_FACE_WAIT = 20'h00100,
        S_EDGE      = 20'h00200,
        S_SCAN_RD   = 20'h00400,
        S_SCAN_CMP  = 20'h00800,
        S_SHIFT_RD  = 20'h01000,
        S_SHIFT_WR  = 20'h02000,
        S_HOR_RD    = 20'h04000,
        S_HOR_PUSH  = 20'h08000,
        S_FIN       = 20'h10000,
        S_OUT_RD    = 20'h20000,
        S_OUT_LD    = 20'h40000,
        S_STAT      = 20'h80000
    } t_state;

    localparam int AW = ichull_pkg::PT_AW;

    t_state                         r_state, n_state;
    ichull_pkg::t_pcnt              r_pcnt, n_pcnt, r_i, n_i;
    ichull_pkg::t_pidx              r_seed, n_seed;
    logic                           r_neg, n_neg;
    ichull_pkg::t_fcnt              r_f, n_f, r_keep, n_keep, r_fcnt, n_fcnt;
    ichull_pkg::t_fcnt              r_emit, n_emit, r_o, n_o;
    ichull_pkg::t_hcnt              r_hcnt, n_hcnt, r_j, n_j, r_h, n_h;
    ichull_pkg::t_esel              r_k, n_k;
    logic [1:0]                     r_s, n_s;
    logic [ichull_pkg::STAT_W-1:0]  r_code, n_code;
    ichull_pkg::t_pidx              w_i;
    ichull_pkg::t_pidx              w_one, w_two;

    assign w_i   = r_i[AW-1:0];
    assign w_one = ichull_pkg::t_pidx'(1);
    assign w_two = ichull_pkg::t_pidx'(2);

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        n_pcnt  = r_pcnt;
        n_i     = r_i;
        n_seed  = r_seed;
        n_neg   = r_neg;
        n_f     = r_f;
        n_keep  = r_keep;
        n_fcnt  = r_fcnt;
        n_emit  = r_emit;
        n_o     = r_o;
        n_hcnt  = r_hcnt;
        n_j     = r_j;
        n_h     = r_h;
        n_k     = r_k;
        n_s     = r_s;
        n_code  = r_code;
        o_cmd          = '0;
        o_cmd.fsrc     = ichull_pkg::FW_LATCH;
        o_cmd.hsrc     = ichull_pkg::HW_EDGE;
        o_cmd.esel     = r_k;
        o_cmd.pidx     = w_i;
        o_cmd.out_code = ichull_pkg::ST_FACE;

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_pcnt < ichull_pkg::PCNT_MAX) begin
                        o_cmd.pt_we   = 1'b1;
                        o_cmd.pt_addr = r_pcnt[AW-1:0];
                        n_pcnt        = r_pcnt + 1'b1;
                    end
                    if (i_in_last) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_fcnt = '0;
                if (r_pcnt < ichull_pkg::PCNT_MIN) begin
                    n_code  = ichull_pkg::ST_FEW;
                    n_state = S_STAT;
                end else begin
                    n_i     = ichull_pkg::PIDX_FIRST;
                    n_state = S_SEED_GO;
                end
            end
            S_SEED_GO: begin
                o_cmd.vol_start = 1'b1;
                o_cmd.tri_a     = '0;
                o_cmd.tri_b     = w_one;
                o_cmd.tri_c     = w_two;
                n_state         = S_SEED_WAIT;
            end
            S_SEED_WAIT: begin
                if (i_stat.vol_done) begin
                    if (i_stat.vol_lt_p || i_stat.vol_gt_p) begin
                        n_neg   = i_stat.vol_lt_p;
                        n_seed  = w_i;
                        n_s     = '0;
                        n_state = S_SEED_PUSH;
                    end else if ((r_i + 1'b1) < r_pcnt) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SEED_GO;
                    end else begin
                        n_code  = ichull_pkg::ST_FLAT;
                        n_state = S_STAT;
                    end
                end
            end
            S_SEED_PUSH: begin
                o_cmd.face_we    = 1'b1;
                o_cmd.face_waddr = ichull_pkg::t_faddr'(r_s);
                o_cmd.fsrc       = ichull_pkg::FW_SEED;
                unique case (r_s)
                    2'd0: begin
                        o_cmd.tri_a = '0;
                        o_cmd.tri_b = r_neg ? w_one : w_two;
                        o_cmd.tri_c = r_neg ? w_two : w_one;
                    end
                    2'd1: begin
                        o_cmd.tri_a = '0;
                        o_cmd.tri_b = r_neg ? w_two : r_seed;
                        o_cmd.tri_c = r_neg ? r_seed : w_two;
                    end
                    2'd2: begin
                        o_cmd.tri_a = '0;
                        o_cmd.tri_b = r_neg ? r_seed : w_one;
                        o_cmd.tri_c = r_neg ? w_one : r_seed;
                    end
                    default: begin
                        o_cmd.tri_a = w_one;
                        o_cmd.tri_b = r_neg ? r_seed : w_two;
                        o_cmd.tri_c = r_neg ? w_two : r_seed;
                    end
                endcase
                n_fcnt = ichull_pkg::t_fcnt'(r_s) + 1'b1;
                n_s    = r_s + 2'd1;
                if (r_s == 2'd3) begin
                    n_i     = ichull_pkg::PIDX_FIRST;
                    n_state = S_ADD_NEXT;
                end
            end
            S_ADD_NEXT: begin
                if (r_i >= r_pcnt) begin
                    n_state = S_FIN;
                end else if (w_i == r_seed) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_hcnt  = '0;
                    n_f     = '0;
                    n_keep  = '0;
                    n_state = S_FACE_RD;
                end
            end
            S_FACE_RD: begin
                if (r_f >= r_fcnt) begin
                    n_fcnt  = r_keep;
                    n_h     = '0;
                    n_state = S_HOR_RD;
                end else begin
                    o_cmd.face_raddr = r_f[ichull_pkg::FA_W-1:0];
                    n_state          = S_FACE_LAT;
                end
            end
            S_FACE_LAT: begin
                o_cmd.face_latch = 1'b1;
                o_cmd.vol_start  = 1'b1;
                o_cmd.vol_face   = 1'b1;
                n_state          = S_FACE_WAIT;
            end
            S_FACE_WAIT: begin
                if (i_stat.vol_done) begin
                    if (i_stat.vol_gt_v) begin
                        n_k     = ichull_pkg::E_AB;
                        n_state = S_EDGE;
                    end else begin
                        o_cmd.face_we    = 1'b1;
                        o_cmd.face_waddr = r_keep[ichull_pkg::FA_W-1:0];
                        n_keep           = r_keep + 1'b1;
                        n_f              = r_f + 1'b1;
                        n_state          = S_FACE_RD;
                    end
                end
            end
            S_EDGE: begin
                n_j     = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_j >= r_hcnt) begin
                    if (r_hcnt < ichull_pkg::HCNT_MAX) begin
                        o_cmd.hor_we    = 1'b1;
                        o_cmd.hor_waddr = r_hcnt[ichull_pkg::HA_W-1:0];
                        n_hcnt          = r_hcnt + 1'b1;
                    end
                    if (r_k == ichull_pkg::E_CA) begin
                        n_f     = r_f + 1'b1;
                        n_state = S_FACE_RD;
                    end else begin
                        n_k     = (r_k == ichull_pkg::E_AB) ? ichull_pkg::E_BC : ichull_pkg::E_CA;
                        n_state = S_EDGE;
                    end
                end else begin
                    o_cmd.hor_raddr = r_j[ichull_pkg::HA_W-1:0];
                    n_state         = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.edge_match) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if ((r_j + 1'b1) < r_hcnt) begin
                    o_cmd.hor_raddr = ichull_pkg::t_haddr'(r_j + 1'b1);
                    n_state         = S_SHIFT_WR;
                end else begin
                    n_hcnt = r_hcnt - 1'b1;
                    if (r_k == ichull_pkg::E_CA) begin
                        n_f     = r_f + 1'b1;
                        n_state = S_FACE_RD;
                    end else begin
                        n_k     = (r_k == ichull_pkg::E_AB) ? ichull_pkg::E_BC : ichull_pkg::E_CA;
                        n_state = S_EDGE;
                    end
                end
            end
            S_SHIFT_WR: begin
                o_cmd.hor_we    = 1'b1;
                o_cmd.hor_waddr = r_j[ichull_pkg::HA_W-1:0];
                o_cmd.hsrc      = ichull_pkg::HW_SHIFT;
                n_j             = r_j + 1'b1;
                n_state         = S_SHIFT_RD;
            end
            S_HOR_RD: begin
                if (r_h >= r_hcnt) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ADD_NEXT;
                end else begin
                    o_cmd.hor_raddr = r_h[ichull_pkg::HA_W-1:0];
                    n_state         = S_HOR_PUSH;
                end
            end
            S_HOR_PUSH: begin
                if (r_fcnt < ichull_pkg::FCNT_MAX) begin
                    o_cmd.face_we    = 1'b1;
                    o_cmd.face_waddr = r_fcnt[ichull_pkg::FA_W-1:0];
                    o_cmd.fsrc       = ichull_pkg::FW_HOR;
                    n_fcnt           = r_fcnt + 1'b1;
                end
                n_h     = r_h + 1'b1;
                n_state = S_HOR_RD;
            end
            S_FIN: begin
                if (r_fcnt == '0) begin
                    n_code  = ichull_pkg::ST_FLAT;
                    n_state = S_STAT;
                end else begin
                    n_emit  = (r_fcnt < ichull_pkg::EMIT_CAP) ? r_fcnt : ichull_pkg::EMIT_CAP;
                    n_o     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                if (i_stat.out_free) begin
                    o_cmd.face_raddr = r_o[ichull_pkg::FA_W-1:0];
                    n_state          = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_face = 1'b1;
                o_cmd.out_last = ((r_o + 1'b1) == r_emit);
                n_o            = r_o + 1'b1;
                if ((r_o + 1'b1) == r_emit) begin
                    n_pcnt  = '0;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_code = r_code;
                    o_cmd.out_last = 1'b1;
                    n_pcnt         = '0;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pcnt  <= '0;
            r_i     <= '0;
            r_seed  <= '0;
            r_neg   <= 1'b0;
            r_f     <= '0;
            r_keep  <= '0;
            r_fcnt  <= '0;
            r_emit  <= '0;
            r_o     <= '0;
            r_hcnt  <= '0;
            r_j     <= '0;
            r_h     <= '0;
            r_k     <= ichull_pkg::E_AB;
            r_s     <= '0;
            r_code  <= ichull_pkg::ST_FACE;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            r_i     <= n_i;
            r_seed  <= n_seed;
            r_neg   <= n_neg;
            r_f     <= n_f;
            r_keep  <= n_keep;
            r_fcnt  <= n_fcnt;
            r_emit  <= n_emit;
            r_o     <= n_o;
            r_hcnt  <= n_hcnt;
            r_j     <= n_j;
            r_h     <= n_h;
            r_k     <= n_k;
            r_s     <= n_s;
            r_code  <= n_code;
        end
    end

    `ICHULL_ASSERT(a_pcnt_cap, r_pcnt <= ichull_pkg::PCNT_MAX, "point count overflow")
    `ICHULL_ASSERT(a_fcnt_cap, r_fcnt <= ichull_pkg::FCNT_MAX, "face count overflow")
    `ICHULL_ASSERT(a_hcnt_cap, r_hcnt <= ichull_pkg::HCNT_MAX, "horizon count overflow")
    `ICHULL_ASSERT_IMP(a_out_free, o_cmd.out_load, i_stat.out_free, "output overwritten")

endmodule
